>>> hdl/assert_macros.svh
// assertion macros shared by the quadrature position counter rtl
// no dependencies; expects clk and rst in the including module's scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clk edge outside reset
`define QPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising clk edge, reset included
`define QPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/qpc_pkg.sv
// shared types, constants and helpers for the quadrature position counter
// no dependencies
`default_nettype none

package qpc_pkg;

  // counter and filter sizes
  localparam int COUNT_BITS  = 64;
  localparam int FILTER_BITS = 10;

  // port field widths
  localparam int POS_W      = 64;
  localparam int CHG_W      = 2;
  localparam int REQ_W      = 3;
  localparam int FILT_CFG_W = 10;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 10;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  localparam int LIM_W = (FILTER_BITS > FILT_CFG_W) ? FILTER_BITS : FILT_CFG_W;

  localparam logic [FILTER_BITS-1:0] FILT_MAX = '1;
  localparam logic [FILT_CFG_W-1:0]  FILT_RESET = FILT_CFG_W'(100);

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ZERO     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PRESET   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_STEP_FWD = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STEP_BWD = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 8'd1;

  // count_change codes
  localparam logic [CHG_W-1:0] CHG_NONE = 2'b00;
  localparam logic [CHG_W-1:0] CHG_UP   = 2'b01;
  localparam logic [CHG_W-1:0] CHG_DOWN = 2'b11;

  // filter status toward the decoder
  typedef struct packed {
    logic level;       // accepted level before this tick
    logic level_next;  // accepted level after this tick
  } filt_t;

  // clamp the configured threshold into the filter counter range
  function automatic logic [FILTER_BITS-1:0] sat_limit(input logic [FILT_CFG_W-1:0] t);
    logic [LIM_W-1:0] t_w;
    t_w = LIM_W'(t);
    if (t_w > LIM_W'(FILT_MAX)) begin
      return FILT_MAX;
    end
    return t_w[FILTER_BITS-1:0];
  endfunction

  // sign-extend the position count to the port width
  function automatic logic [POS_W-1:0] sext_pos(input logic [COUNT_BITS-1:0] v);
    return POS_W'(signed'(v));
  endfunction

endpackage

`default_nettype wire

>>> hdl/qpc_pin_filter.sv
// glitch filter for one encoder pin: holds the accepted level and its stability counter
// depends on qpc_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module qpc_pin_filter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          tick,
  input  wire logic                          raw,
  input  wire logic [qpc_pkg::FILTER_BITS-1:0] limit,
  output qpc_pkg::filt_t                     st
);

  logic                          level;
  logic                          level_next;
  logic [qpc_pkg::FILTER_BITS-1:0] cnt;
  logic [qpc_pkg::FILTER_BITS-1:0] cnt_next;
  logic [qpc_pkg::FILTER_BITS-1:0] cnt_inc;

  always_comb begin
    cnt_inc = (cnt != qpc_pkg::FILT_MAX) ? cnt + 1'b1 : cnt;
    priority if (raw == level) begin
      // level back at accepted value restarts the count
      level_next = level;
      cnt_next   = '0;
    end else if (cnt_inc >= limit) begin
      level_next = raw;
      cnt_next   = '0;
    end else begin
      level_next = level;
      cnt_next   = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 1'b0;
      cnt   <= '0;
    end else if (tick) begin
      level <= level_next;
      cnt   <= cnt_next;
    end
  end

  assign st.level      = level;
  assign st.level_next = level_next;

  `QPC_ASSERT(a_cnt_clear_on_match, tick && raw == level |=> cnt == '0, "filter count not cleared")
  `QPC_ASSERT(a_level_only_on_tick, !tick |=> $stable(level), "level moved without a tick")

endmodule

`default_nettype wire

>>> hdl/quadrature_position_counter.sv
// quadrature position counter top level: request stage, x4 decode and position register
// depends on qpc_pkg, qpc_pin_filter and assert_macros.svh
`default_nettype none

// flow: an accepted request waits in the input register and moves into the result register
// once that register is empty or its result is being taken
// throughput: one request per cycle while results are taken; one input register and one
// output register with the update logic between them; s_axis_tready follows m_axis_tready,
// so a full pipeline still takes a request in every cycle in which a result is taken
// reset: rst is synchronous, active high; clears the position, the pin filters,
// invert_direction and sets filter_ticks to 100; no clearing pass

`include "assert_macros.svh"

module quadrature_position_counter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [qpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [qpc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // request stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [0] pin_a, [1] pin_b, [65:2] preset_count, [71:66] zero
  input  wire logic [qpc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [2:0] req_type
  input  wire logic [qpc_pkg::REQ_W-1:0]         s_axis_tuser,
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [63:0] position_count, [65:64] count_change, [71:66] zero
  output logic [qpc_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

  // configuration registers
  logic                              invert;
  logic [qpc_pkg::FILT_CFG_W-1:0]    filter_ticks;

  // input register
  logic                              s1_valid;
  logic [qpc_pkg::REQ_W-1:0]         s1_req;
  logic                              s1_pin_a;
  logic                              s1_pin_b;
  logic [qpc_pkg::COUNT_BITS-1:0]    s1_preset;

  // position and output register
  logic [qpc_pkg::COUNT_BITS-1:0]    pos;
  logic [qpc_pkg::COUNT_BITS-1:0]    pos_next;
  logic [qpc_pkg::CHG_W-1:0]         chg_next;
  logic [qpc_pkg::POS_W-1:0]         out_pos;
  logic [qpc_pkg::CHG_W-1:0]         out_chg;

  logic                              adv;      // input register moves into the output register
  logic                              tick;
  logic [qpc_pkg::FILTER_BITS-1:0]   limit;
  qpc_pkg::filt_t                    filt_a;
  qpc_pkg::filt_t                    filt_b;
  logic                              a_chg;
  logic                              b_chg;
  logic                              edge_up;

  // config always taken; the user must write it only while idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert       <= 1'b0;
      filter_ticks <= qpc_pkg::FILT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == qpc_pkg::CFG_INVERT) begin
        invert <= cfg_data[0];
      end else if (cfg_index == qpc_pkg::CFG_FILTER) begin
        filter_ticks <= cfg_data[qpc_pkg::FILT_CFG_W-1:0];
      end
    end
  end

  // pipeline flow: output register frees when empty or taken this cycle
  assign adv           = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_req    <= s_axis_tuser;
      s1_pin_a  <= s_axis_tdata[0];
      s1_pin_b  <= s_axis_tdata[1];
      s1_preset <= s_axis_tdata[qpc_pkg::COUNT_BITS+1:2];
    end
  end

  // per-pin glitch filters, updated only on sample ticks
  assign tick  = adv && (s1_req == qpc_pkg::REQ_TICK);
  assign limit = qpc_pkg::sat_limit(filter_ticks);

  qpc_pin_filter u_filt_a (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick),
    .raw   (s1_pin_a),
    .limit (limit),
    .st    (filt_a)
  );

  qpc_pin_filter u_filt_b (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick),
    .raw   (s1_pin_b),
    .limit (limit),
    .st    (filt_b)
  );

  // x4 decode: both pins moving in one tick cancel out
  always_comb begin
    a_chg = filt_a.level_next != filt_a.level;
    b_chg = filt_b.level_next != filt_b.level;
    if (a_chg) begin
      edge_up = (filt_a.level_next == filt_b.level_next) ^ invert;
    end else begin
      edge_up = (filt_a.level_next != filt_b.level_next) ^ invert;
    end
  end

  // position update for the request in the input register
  always_comb begin
    pos_next = pos;
    chg_next = qpc_pkg::CHG_NONE;
    unique case (s1_req)
      qpc_pkg::REQ_TICK: begin
        if (a_chg ^ b_chg) begin
          if (edge_up) begin
            pos_next = pos + 1'b1;
            chg_next = qpc_pkg::CHG_UP;
          end else begin
            pos_next = pos - 1'b1;
            chg_next = qpc_pkg::CHG_DOWN;
          end
        end
      end
      qpc_pkg::REQ_ZERO: begin
        pos_next = '0;
      end
      qpc_pkg::REQ_PRESET: begin
        pos_next = s1_preset;
      end
      qpc_pkg::REQ_STEP_FWD: begin
        pos_next = pos + 1'b1;
        chg_next = qpc_pkg::CHG_UP;
      end
      qpc_pkg::REQ_STEP_BWD: begin
        pos_next = pos - 1'b1;
        chg_next = qpc_pkg::CHG_DOWN;
      end
      default: begin
        // unused codes report the position unchanged
        pos_next = pos;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        pos <= pos_next;
      end
      if (adv) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pos <= qpc_pkg::sext_pos(pos_next);
      out_chg <= chg_next;
    end
  end

  assign m_axis_tdata = {(qpc_pkg::OUT_DATA_W - qpc_pkg::POS_W - qpc_pkg::CHG_W)'(0),
                         out_chg, out_pos};

  // the shown result always matches the live position
  `QPC_ASSERT(a_out_tracks_pos, m_axis_tvalid |-> out_pos == qpc_pkg::sext_pos(pos), "stale result")
  // change code is never the unused pattern
  `QPC_ASSERT(a_chg_code, m_axis_tvalid |-> out_chg != 2'b10, "bad count_change code")
  // a held request is not dropped
  `QPC_ASSERT(a_s1_hold, s1_valid && !adv |=> s1_valid && $stable(s1_req), "held request lost")
  `QPC_ASSERT_ALWAYS(a_reset_empty, rst |=> !s1_valid && !m_axis_tvalid, "not empty after reset")

endmodule

`default_nettype wire

>>> dv/quadrature_position_counter_tb.sv
// self-checking testbench for the quadrature position counter: drives requests and
// configuration writes, predicts every result and compares it field by field
// depends on qpc_pkg and the quadrature_position_counter rtl
`timescale 1ns / 1ps

module quadrature_position_counter_tb;

  // extremes of the position count
  localparam logic [qpc_pkg::POS_W-1:0] POS_MAX = {1'b0, {(qpc_pkg::POS_W-1){1'b1}}};
  localparam logic [qpc_pkg::POS_W-1:0] POS_MIN = {1'b1, {(qpc_pkg::POS_W-1){1'b0}}};
  // request codes past the defined ones run up to this
  localparam logic [qpc_pkg::REQ_W-1:0] REQ_LAST = '1;
  // register indexes outside the map, writes there must be dropped
  localparam logic [qpc_pkg::CFG_IDX_W-1:0] CFG_SPARE = qpc_pkg::CFG_FILTER + 1'b1;
  localparam logic [qpc_pkg::CFG_IDX_W-1:0] CFG_TOP   = '1;
  // threshold for the long dwell section
  localparam int FILT_LONG = 40;

  typedef struct {
    logic [qpc_pkg::POS_W-1:0] position;
    logic [qpc_pkg::CHG_W-1:0] change;
  } count_result_t;

  // mirrors the counter state and holds the results still owed by the block
  class position_scoreboard;
    bit                              invert;
    logic [qpc_pkg::FILTER_BITS-1:0] filt_limit;
    logic [1:0]                      levels;      // accepted pins, bit 0 is a
    logic [qpc_pkg::FILTER_BITS-1:0] stable[2];
    logic [qpc_pkg::COUNT_BITS-1:0]  total;
    count_result_t                   owed_q[$];
    int                              errors;

    function new();
      invert     = 1'b0;
      filt_limit = qpc_pkg::FILTER_BITS'(qpc_pkg::FILT_RESET);
      levels     = '0;
      stable[0]  = '0;
      stable[1]  = '0;
      total      = '0;
      errors     = 0;
    endfunction

    function void write_reg(input logic [qpc_pkg::CFG_IDX_W-1:0] idx,
                            input logic [qpc_pkg::CFG_DATA_W-1:0] value);
      if (idx == qpc_pkg::CFG_INVERT) begin
        invert = value[0];
      end else if (idx == qpc_pkg::CFG_FILTER) begin
        filt_limit = value[qpc_pkg::FILTER_BITS-1:0];
      end
    endfunction

    // glitch filter of one pin, returns the accepted level after the tick
    function logic filter_pin(input int idx, input logic raw, input logic held);
      if (raw == held) begin
        stable[idx] = '0;
        return held;
      end
      if (stable[idx] != qpc_pkg::FILT_MAX) begin
        stable[idx]++;
      end
      // a limit of zero accepts on the first differing tick, same as one
      if (stable[idx] >= filt_limit) begin
        stable[idx] = '0;
        return raw;
      end
      return held;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    task note_request(input logic [qpc_pkg::REQ_W-1:0] req, input logic pin_a,
                      input logic pin_b, input logic [qpc_pkg::POS_W-1:0] preset);
      logic          old_a, old_b, new_a, new_b;
      int            step;
      count_result_t r;
      step = 0;
      case (req)
        qpc_pkg::REQ_TICK: begin
          old_a = levels[0];
          old_b = levels[1];
          new_a = filter_pin(0, pin_a, old_a);
          new_b = filter_pin(1, pin_b, old_b);
          // x4 decode, both pins moving in one tick cancel out
          if (new_a != old_a) step += (new_a == new_b) ? 1 : -1;
          if (new_b != old_b) step += (new_a != new_b) ? 1 : -1;
          levels = {new_b, new_a};
          if (invert) step = -step;
        end
        qpc_pkg::REQ_ZERO:     total = '0;
        qpc_pkg::REQ_PRESET:   total = preset[qpc_pkg::COUNT_BITS-1:0];
        qpc_pkg::REQ_STEP_FWD: step = 1;
        qpc_pkg::REQ_STEP_BWD: step = -1;
        default: ;
      endcase
      if (step > 0) begin
        total = total + 1'b1;
      end else if (step < 0) begin
        total = total - 1'b1;
      end
      r.position = qpc_pkg::POS_W'(signed'(total));
      r.change   = (step > 0) ? qpc_pkg::CHG_UP :
                   ((step < 0) ? qpc_pkg::CHG_DOWN : qpc_pkg::CHG_NONE);
      owed_q.push_back(r);
    endtask

    task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      errors++;
      $display("mismatch on %s: got %h, expected %h", what, got, want);
    endtask

    task check_result(input logic [qpc_pkg::OUT_DATA_W-1:0] data);
      count_result_t want;
      if (owed_q.size() == 0) begin
        report_mismatch("result with nothing owed", data[63:0], 'x);
        return;
      end
      want = owed_q.pop_front();
      if (data[qpc_pkg::POS_W-1:0] !== want.position) begin
        report_mismatch("position_count", data[qpc_pkg::POS_W-1:0], want.position);
      end
      if (data[qpc_pkg::POS_W+qpc_pkg::CHG_W-1:qpc_pkg::POS_W] !== want.change) begin
        report_mismatch("count_change",
                        64'(data[qpc_pkg::POS_W+qpc_pkg::CHG_W-1:qpc_pkg::POS_W]),
                        64'(want.change));
      end
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [qpc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [qpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // [0] pin_a, [1] pin_b, [65:2] preset_count
  logic [qpc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [qpc_pkg::REQ_W-1:0]      s_axis_tuser = '0;   // [2:0] req_type
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // [63:0] position_count, [65:64] count_change
  logic [qpc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // quiet turns off idling on both sides
  bit quiet = 1'b0;
  int stall_left = 0;
  int stall_pick;

  position_scoreboard sb = new();

  quadrature_position_counter dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watch all three channels; values read here are the ones before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_request(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[1],
                        s_axis_tdata[qpc_pkg::POS_W+1:2]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
      end
    end
  end

  // result side back-pressure: mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin
    if (rst || quiet) begin
      m_axis_tready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left = (stall_pick < 94) ? $urandom_range(0, 2) : $urandom_range(9, 29);
      end
    end
  end

  // run ends here if the block hangs
  initial begin
    #4ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [qpc_pkg::POS_W-1:0] random_count();
    logic [qpc_pkg::POS_W-1:0] v;
    v = {$urandom(), $urandom()};
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: v = POS_MAX;
        1: v = POS_MIN;
        2: v = '1;
        default: v = '0;
      endcase
    end
    return v;
  endfunction

  // pin levels {b, a} at a position of the quadrature cycle
  function automatic logic [1:0] quad_pins(input int q);
    case (q & 3)
      0: return 2'b00;
      1: return 2'b01;
      2: return 2'b11;
      default: return 2'b10;
    endcase
  endfunction

  // one request transaction; tvalid stays high across back-to-back items
  task automatic send_item(input logic [qpc_pkg::REQ_W-1:0] req, input logic [1:0] pins,
                           input logic [qpc_pkg::POS_W-1:0] preset);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {{(qpc_pkg::IN_DATA_W-qpc_pkg::POS_W-2){1'b0}}, preset, pins};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_tick(input logic [1:0] pins);
    send_item(qpc_pkg::REQ_TICK, pins, random_count());
  endtask

  task automatic send_op(input logic [qpc_pkg::REQ_W-1:0] req,
                         input logic [qpc_pkg::POS_W-1:0] value);
    send_item(req, {1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))}, value);
  endtask

  task automatic send_other();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) send_op(qpc_pkg::REQ_ZERO, random_count());
    else if (pick < 45) send_op(qpc_pkg::REQ_PRESET, random_count());
    else if (pick < 70) send_op(qpc_pkg::REQ_STEP_FWD, random_count());
    else if (pick < 92) send_op(qpc_pkg::REQ_STEP_BWD, random_count());
    else send_op(qpc_pkg::REQ_W'($urandom_range(int'(qpc_pkg::REQ_STEP_BWD) + 1,
                                                int'(REQ_LAST))),
                 random_count());
  endtask

  // hold off the source until every owed result is back
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // config transaction, only issued while the block is idle
  task automatic write_reg(input logic [qpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qpc_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random traffic: mostly clean quadrature walks with dwell at or past the filter
  // threshold, mixed with glitches that return early, raw noise and other requests
  task automatic run_phase(input int n_items, input int filt);
    int sent, eff, hold, pick, q, dir;
    logic [1:0] pins;
    sent = 0;
    q    = 0;
    dir  = $urandom_range(0, 1) ? 1 : 3;
    eff  = (filt == 0) ? 1 : filt;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_other();
        sent++;
      end else if (pick < 22) begin
        send_tick(2'($urandom_range(0, 3)));
        sent++;
      end else if (pick < 32 && eff > 1) begin
        // glitch shorter than the threshold, filter must drop it
        pins = quad_pins(q + (($urandom_range(0, 1) != 0) ? 1 : 3));
        hold = $urandom_range(1, eff - 1);
        repeat (hold) send_tick(pins);
        sent += hold;
      end else begin
        if ($urandom_range(0, 9) == 0) q += 2;                  // both pins at once
        else if ($urandom_range(0, 3) == 0) q += 4 - dir;       // reversal
        else q += dir;
        hold = eff + $urandom_range(0, 2);
        repeat (hold) send_tick(quad_pins(q));
        sent += hold;
      end
      if ($urandom_range(0, 99) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  initial begin
    int filt;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: filter at 100, direction normal
    send_op(qpc_pkg::REQ_ZERO, '1);
    send_op(qpc_pkg::REQ_PRESET, POS_MAX);
    send_op(qpc_pkg::REQ_STEP_FWD, '0);        // wraps to the most negative count
    send_op(qpc_pkg::REQ_STEP_BWD, '0);        // and back
    send_op(qpc_pkg::REQ_PRESET, POS_MIN);
    send_op(qpc_pkg::REQ_STEP_BWD, '1);
    send_op(qpc_pkg::REQ_PRESET, '1);
    send_op(qpc_pkg::REQ_STEP_FWD, POS_MIN);   // -1 up to zero
    for (int r = int'(qpc_pkg::REQ_STEP_BWD) + 1; r <= int'(REQ_LAST); r++) begin
      send_op(qpc_pkg::REQ_W'(r), random_count());
    end
    send_tick(2'b11);                 // far short of 100 ticks, no edge
    send_tick(2'b11);
    wait_for_results();

    // writes outside the map are dropped
    write_reg(CFG_TOP, '1);
    write_reg(CFG_SPARE, qpc_pkg::CFG_DATA_W'($urandom()));
    // zero threshold takes a new level on its first tick
    write_reg(qpc_pkg::CFG_FILTER, '0);
    send_tick(2'b01);
    send_tick(2'b11);
    send_tick(2'b10);
    send_tick(2'b00);
    send_tick(2'b10);
    send_tick(2'b11);
    send_tick(2'b01);
    send_tick(2'b00);
    send_tick(2'b11);                 // both pins in one tick net to zero
    send_tick(2'b00);
    wait_for_results();
    // invert with the unused data bits set; requested steps keep their sign
    write_reg(qpc_pkg::CFG_INVERT, '1);
    send_tick(2'b01);
    send_tick(2'b00);
    send_op(qpc_pkg::REQ_STEP_FWD, '0);
    wait_for_results();
    write_reg(qpc_pkg::CFG_INVERT, '0);

    // largest threshold: a short pulse on a is dropped
    quiet = 1'b1;
    write_reg(qpc_pkg::CFG_FILTER, qpc_pkg::FILT_MAX);
    repeat (20) send_tick(2'b01);
    send_tick(2'b00);
    wait_for_results();
    // long threshold, no idling: one tick short and the early return clears
    // the counter, then a full dwell gets each pin through
    write_reg(qpc_pkg::CFG_FILTER, qpc_pkg::CFG_DATA_W'(FILT_LONG));
    repeat (FILT_LONG - 1) send_tick(2'b01);
    send_tick(2'b00);
    repeat (FILT_LONG) send_tick(2'b01);
    repeat (FILT_LONG) send_tick(2'b11);
    wait_for_results();
    quiet = 1'b0;

    // random phases, alternating direction, mostly small thresholds
    for (int p = 0; p < 6; p++) begin
      filt = (p < 4) ? p : $urandom_range(0, 6);
      write_reg(qpc_pkg::CFG_INVERT, {(qpc_pkg::CFG_DATA_W-1)'($urandom()), p[0]});
      write_reg(qpc_pkg::CFG_FILTER, qpc_pkg::CFG_DATA_W'(filt));
      quiet = (p == 5) || ($urandom_range(0, 4) == 0);
      run_phase(60, filt);
    end
    quiet = 1'b0;

    wait_for_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/qpc_pkg.sv
hdl/qpc_pin_filter.sv
hdl/quadrature_position_counter.sv
dv/quadrature_position_counter_tb.sv
